/* rtl/core/lzw_pkg.sv */
// shared types, constants and helpers of the lzw compressor
`timescale 1ns / 1ps
package lzw_pkg;

  localparam int DICT_ENTRIES = 4096;
  localparam int DICT_AW      = $clog2(DICT_ENTRIES);
  localparam int COUNT_BITS   = 32;
  localparam int CNT_IDX_W    = $clog2(COUNT_BITS);
  localparam int PROD_W       = COUNT_BITS + 7;
  localparam int CODE_EOS     = 256;
  localparam int CODE_CLEAR   = 257;
  localparam int CODE_FIRST   = 258;
  localparam int ROOTS        = 256;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int PEND_DEPTH   = 8;
  localparam int PEND_AW      = $clog2(PEND_DEPTH);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PERCENT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERCENT_CAP    = 2'd2;

  typedef enum logic [2:0] {
    F_IDLE, F_RDC, F_WALK, F_WR1, F_WR2, F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_MOD, B_MISS, B_CLR, B_CNT, B_PMUL, B_PCMP,
    B_FIN, B_END, B_FLUSH, B_FMUL, B_FCMP, B_OUT
  } back_state_t;

  typedef struct packed {
    logic               first;
    logic               last;
    logic               miss_v;
    logic               clr_v;
    logic [DICT_AW-1:0] miss_code;
    logic [3:0]         miss_w;
    logic [DICT_AW-1:0] fin_code;
    logic [3:0]         fin_w;
    logic [3:0]         end_w;
  } cmd_t;

  function automatic logic [3:0] code_width(input logic [DICT_AW:0] n);
    logic [3:0] w;
    if (n > 13'd2048) w = 4'd12;
    else if (n > 13'd1024) w = 4'd11;
    else if (n > 13'd512) w = 4'd10;
    else w = 4'd9;
    return w;
  endfunction

endpackage

/* rtl/core/lzw_if.sv */
// word channel interfaces of the lzw compressor
`timescale 1ns / 1ps
interface lzw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_end;
  logic       rejected;
  modport source (output valid, output out_byte, output run_last, output stream_end,
                  output rejected, input ready);
  modport sink (input valid, input out_byte, input run_last, input stream_end,
                input rejected, output ready);
endinterface

/* rtl/core/lzw_front.sv */
// dictionary search front end: walks the trie and issues packing commands
`timescale 1ns / 1ps
module lzw_front
  import lzw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  lzw_in_if.sink    in_ch,
  output cmd_t      cmd,
  output logic      cmd_valid,
  input  logic      cmd_ready
);

  front_state_t state_r, state_nxt;

  logic [7:0]         byte_r, byte_nxt;
  logic               last_r, last_nxt;
  logic               first_r, first_nxt;
  logic               miss_r, miss_nxt;
  logic               clr_r, clr_nxt;
  logic [DICT_AW-1:0] miss_code_r, miss_code_nxt;
  logic [3:0]         miss_w_r, miss_w_nxt;
  logic [DICT_AW-1:0] prefix_r, prefix_nxt;
  logic               pvalid_r, pvalid_nxt;
  logic [DICT_AW:0]   next_code_r, next_code_nxt;
  logic [DICT_AW-1:0] sn_r, sn_nxt;
  logic [DICT_AW-1:0] sp_r, sp_nxt;
  logic               sp_is_s_r, sp_is_s_nxt;
  logic [ROOTS-1:0]   root_valid_r, root_valid_nxt;

  logic [DICT_AW-1:0] child_mem [DICT_ENTRIES];
  logic [DICT_AW-1:0] sib_mem [DICT_ENTRIES];
  logic [7:0]         sym_mem [DICT_ENTRIES];
  logic [DICT_AW-1:0] child_q, sib_q;
  logic [7:0]         sym_q;

  logic [DICT_AW-1:0] rd_addr, child_eff, nc;
  logic [DICT_AW:0]   nc_inc;
  logic               child_we, sib_we, sym_we;
  logic [DICT_AW-1:0] child_wa, child_wd, sib_wa, sib_wd;
  logic               prefix_root;

  assign nc          = next_code_r[DICT_AW-1:0];
  assign nc_inc      = next_code_r + 1'b1;
  assign prefix_root = (prefix_r[DICT_AW-1:8] == '0);
  assign child_eff   = (prefix_root && !root_valid_r[prefix_r[7:0]]) ? '0 : child_q;

  always_comb begin
    case (state_r)
      F_RDC:   rd_addr = child_eff;
      F_WALK:  rd_addr = sib_q;
      default: rd_addr = prefix_r;
    endcase
  end

  always_ff @(posedge clk) begin
    child_q <= child_mem[rd_addr];
    if (child_we) child_mem[child_wa] <= child_wd;
  end

  always_ff @(posedge clk) begin
    sib_q <= sib_mem[rd_addr];
    if (sib_we) sib_mem[sib_wa] <= sib_wd;
  end

  always_ff @(posedge clk) begin
    sym_q <= sym_mem[rd_addr];
    if (sym_we) sym_mem[nc] <= byte_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (in_ch.valid) state_nxt = pvalid_r ? F_RDC : F_PUSH;
      end
      F_RDC: begin
        state_nxt = (child_eff == '0) ? F_WR1 : F_WALK;
      end
      F_WALK: begin
        if (sym_q == byte_r) state_nxt = F_PUSH;
        else if (sib_q == '0) state_nxt = F_WR1;
      end
      F_WR1: state_nxt = F_WR2;
      F_WR2: state_nxt = F_PUSH;
      F_PUSH: begin
        if (cmd_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    byte_nxt       = byte_r;
    last_nxt       = last_r;
    first_nxt      = first_r;
    miss_nxt       = miss_r;
    clr_nxt        = clr_r;
    miss_code_nxt  = miss_code_r;
    miss_w_nxt     = miss_w_r;
    prefix_nxt     = prefix_r;
    pvalid_nxt     = pvalid_r;
    next_code_nxt  = next_code_r;
    sn_nxt         = sn_r;
    sp_nxt         = sp_r;
    sp_is_s_nxt    = sp_is_s_r;
    root_valid_nxt = root_valid_r;
    child_we       = 1'b0;
    child_wa       = nc;
    child_wd       = '0;
    sib_we         = 1'b0;
    sib_wa         = nc;
    sib_wd         = '0;
    sym_we         = 1'b0;
    in_ch.ready    = 1'b0;
    cmd_valid      = 1'b0;
    case (state_r)
      F_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          byte_nxt  = in_ch.in_byte;
          last_nxt  = in_ch.in_last;
          first_nxt = !pvalid_r;
          miss_nxt  = 1'b0;
          clr_nxt   = 1'b0;
          if (!pvalid_r) begin
            prefix_nxt = {{(DICT_AW-8){1'b0}}, in_ch.in_byte};
            pvalid_nxt = 1'b1;
          end
        end
      end
      F_RDC: begin
        sn_nxt      = child_eff;
        sp_is_s_nxt = 1'b1;
      end
      F_WALK: begin
        if (sym_q == byte_r) begin
          prefix_nxt = sn_r;
        end else begin
          sp_nxt      = sn_r;
          sp_is_s_nxt = 1'b0;
          sn_nxt      = sib_q;
        end
      end
      F_WR1: begin
        miss_nxt      = 1'b1;
        miss_code_nxt = prefix_r;
        miss_w_nxt    = code_width(next_code_r);
        if (sp_is_s_r) begin
          child_we = 1'b1;
          child_wa = prefix_r;
          child_wd = nc;
          if (prefix_root) root_valid_nxt[prefix_r[7:0]] = 1'b1;
        end else begin
          sib_we = 1'b1;
          sib_wa = sp_r;
          sib_wd = nc;
        end
      end
      F_WR2: begin
        child_we   = 1'b1;
        sib_we     = 1'b1;
        sym_we     = 1'b1;
        prefix_nxt = {{(DICT_AW-8){1'b0}}, byte_r};
        if (nc_inc >= (DICT_AW+1)'(DICT_ENTRIES)) begin
          clr_nxt        = 1'b1;
          root_valid_nxt = '0;
          next_code_nxt  = (DICT_AW+1)'(CODE_FIRST);
        end else begin
          next_code_nxt = nc_inc;
        end
      end
      F_PUSH: begin
        cmd_valid = 1'b1;
        if (cmd_ready && last_r) begin
          pvalid_nxt     = 1'b0;
          next_code_nxt  = (DICT_AW+1)'(CODE_FIRST);
          root_valid_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd.first     = first_r;
    cmd.last      = last_r;
    cmd.miss_v    = miss_r;
    cmd.clr_v     = clr_r;
    cmd.miss_code = miss_code_r;
    cmd.miss_w    = miss_w_r;
    cmd.fin_code  = prefix_r;
    cmd.fin_w     = code_width(next_code_r);
    cmd.end_w     = code_width(nc_inc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= F_IDLE;
      pvalid_r     <= 1'b0;
      next_code_r  <= (DICT_AW+1)'(CODE_FIRST);
      root_valid_r <= '0;
    end else begin
      state_r      <= state_nxt;
      pvalid_r     <= pvalid_nxt;
      next_code_r  <= next_code_nxt;
      root_valid_r <= root_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    last_r      <= last_nxt;
    first_r     <= first_nxt;
    miss_r      <= miss_nxt;
    clr_r       <= clr_nxt;
    miss_code_r <= miss_code_nxt;
    miss_w_r    <= miss_w_nxt;
    prefix_r    <= prefix_nxt;
    sn_r        <= sn_nxt;
    sp_r        <= sp_nxt;
    sp_is_s_r   <= sp_is_s_nxt;
  end

endmodule

/* rtl/core/lzw_fifo.sv */
// command queue between the search front end and the packing back end
`timescale 1ns / 1ps
module lzw_fifo
  import lzw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cmd_t push_data,
  input  logic push_valid,
  output logic push_ready,
  output cmd_t pop_data,
  output logic pop_valid,
  input  logic pop_ready
);

  cmd_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign push_ready = (cnt_r != (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/lzw_back.sv */
// packing back end: bit packer, byte counters, ratio checks and result words
`timescale 1ns / 1ps
module lzw_back
  import lzw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata,
  lzw_out_if.source            out_ch
);

  back_state_t state_r, state_nxt;

  cmd_t                  cmd_r, cmd_nxt;
  logic [15:0]           ci_r, ci_nxt;
  logic [6:0]            sp_r, sp_nxt;
  logic [6:0]            cap_r, cap_nxt;
  logic [6:0]            rp_r, rp_nxt;
  logic [COUNT_BITS-1:0] cons_r, cons_nxt;
  logic [COUNT_BITS-1:0] emit_r, emit_nxt;
  logic [15:0]           rem_r, rem_nxt;
  logic [7:0]            buf_r, buf_nxt;
  logic [2:0]            held_r, held_nxt;
  logic                  abort_r, abort_nxt;
  logic [PEND_AW:0]      npend_r, npend_nxt;
  logic [PEND_AW-1:0]    oidx_r, oidx_nxt;
  logic                  rej_r, rej_nxt;
  logic                  modp_r, modp_nxt;
  logic [CNT_IDX_W-1:0]  mcnt_r, mcnt_nxt;
  logic [16:0]           macc_r, macc_nxt;
  logic [COUNT_BITS-1:0] msh_r, msh_nxt;
  logic [PROD_W-1:0]     pa_r, pa_nxt, pb_r, pb_nxt;
  logic                  lt_r, lt_nxt;
  logic                  neg_r, neg_nxt;
  logic                  zero_r, zero_nxt;
  logic [7:0]            pend_r [PEND_DEPTH];

  logic [DICT_AW-1:0]    pk_code, pk_mask;
  logic [3:0]            pk_w;
  logic [19:0]           acc;
  logic [4:0]            nbits;
  logic [1:0]            nb;
  logic [7:0]            pk_buf;
  logic                  pw0_en, pw1_en;
  logic [PEND_AW-1:0]    pw0_a, pw1_a;
  logic [7:0]            pw0_d, pw1_d;

  logic [COUNT_BITS-1:0] cons_inc;
  logic [16:0]           rem_inc;
  logic [15:0]           rem_step;
  logic                  due;
  logic [COUNT_BITS:0]   saved;
  logic [COUNT_BITS-1:0] pdiff, fdiff;
  logic                  fneg;
  logic [16:0]           mtry;
  logic                  pfail, ffail, run_last, done_out, stream_clr;
  logic [7:0]            rp2;

  function automatic logic [PROD_W-1:0] times100(input logic [COUNT_BITS-1:0] d);
    logic [PROD_W-1:0] e;
    e = {7'b0, d};
    return (e << 6) + (e << 5) + (e << 2);
  endfunction

  // bit packer
  always_comb begin
    case (state_r)
      B_CLR: begin
        pk_code = DICT_AW'(CODE_CLEAR);
        pk_w    = 4'd12;
      end
      B_FIN: begin
        pk_code = cmd_r.fin_code;
        pk_w    = cmd_r.fin_w;
      end
      B_END: begin
        pk_code = DICT_AW'(CODE_EOS);
        pk_w    = cmd_r.end_w;
      end
      default: begin
        pk_code = cmd_r.miss_code;
        pk_w    = cmd_r.miss_w;
      end
    endcase
    pk_mask = ~({DICT_AW{1'b1}} << pk_w);
    acc     = {12'b0, buf_r} | ({8'b0, pk_code & pk_mask} << held_r);
    nbits   = {2'b0, held_r} + {1'b0, pk_w};
    nb      = nbits[4] ? 2'd2 : (nbits[3] ? 2'd1 : 2'd0);
    if (nbits[4]) pk_buf = {4'b0, acc[19:16]};
    else if (nbits[3]) pk_buf = acc[15:8];
    else pk_buf = acc[7:0];
  end

  // counters and checks
  always_comb begin
    cons_inc = cons_r + 1'b1;
    rem_inc  = {1'b0, rem_r} + 1'b1;
    if (cons_inc == '0) rem_step = '0;
    else if (rem_inc == {1'b0, ci_r}) rem_step = '0;
    else rem_step = rem_inc[15:0];
    due   = (ci_r != '0) && (cons_inc != '0) && (rem_step == '0);
    saved = {1'b0, emit_r} + (COUNT_BITS+1)'((held_r != '0) || (emit_r == '0));
    pdiff = cons_r - saved[COUNT_BITS-1:0];
    fneg  = emit_r > cons_r;
    fdiff = fneg ? emit_r - cons_r : cons_r - emit_r;
    pfail = lt_r || (pa_r < pb_r);
    ffail = !zero_r && (neg_r ? ((rp_r != '0) || (pa_r >= pb_r)) : (pa_r < pb_r));
    rp2   = {rp_r, 1'b0};
    mtry  = {macc_r[15:0], msh_r[COUNT_BITS-1]};
  end

  assign run_last   = ({1'b0, oidx_r} + 1'b1) == npend_r;
  assign done_out   = (npend_r == '0) || (out_ch.ready && run_last);
  assign cmd_ready  = (state_r == B_IDLE) && !modp_r;

  assign out_ch.valid      = (state_r == B_OUT) && (npend_r != '0);
  assign out_ch.out_byte   = rej_r ? 8'd0 : pend_r[oidx_r];
  assign out_ch.run_last   = run_last;
  assign out_ch.stream_end = cmd_r.last && run_last && !rej_r;
  assign out_ch.rejected   = rej_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (modp_r) state_nxt = B_MOD;
        else if (cmd_valid && !abort_r) state_nxt = cmd.miss_v ? B_MISS : B_CNT;
      end
      B_MOD: begin
        if (mcnt_r == CNT_IDX_W'(COUNT_BITS-1)) state_nxt = B_IDLE;
      end
      B_MISS: state_nxt = cmd_r.clr_v ? B_CLR : B_CNT;
      B_CLR:  state_nxt = B_CNT;
      B_CNT: begin
        if (due) state_nxt = B_PMUL;
        else state_nxt = cmd_r.last ? B_FIN : B_OUT;
      end
      B_PMUL: state_nxt = B_PCMP;
      B_PCMP: begin
        if (pfail) state_nxt = B_OUT;
        else state_nxt = cmd_r.last ? B_FIN : B_OUT;
      end
      B_FIN:   state_nxt = B_END;
      B_END:   state_nxt = B_FLUSH;
      B_FLUSH: state_nxt = B_FMUL;
      B_FMUL:  state_nxt = B_FCMP;
      B_FCMP:  state_nxt = B_OUT;
      B_OUT: begin
        if (done_out) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    cmd_nxt    = cmd_r;
    ci_nxt     = ci_r;
    sp_nxt     = sp_r;
    cap_nxt    = cap_r;
    rp_nxt     = rp_r;
    cons_nxt   = cons_r;
    emit_nxt   = emit_r;
    rem_nxt    = rem_r;
    buf_nxt    = buf_r;
    held_nxt   = held_r;
    abort_nxt  = abort_r;
    npend_nxt  = npend_r;
    oidx_nxt   = oidx_r;
    rej_nxt    = rej_r;
    modp_nxt   = modp_r;
    mcnt_nxt   = mcnt_r;
    macc_nxt   = macc_r;
    msh_nxt    = msh_r;
    pa_nxt     = pa_r;
    pb_nxt     = pb_r;
    lt_nxt     = lt_r;
    neg_nxt    = neg_r;
    zero_nxt   = zero_r;
    pw0_en     = 1'b0;
    pw1_en     = 1'b0;
    pw0_a      = npend_r[PEND_AW-1:0];
    pw1_a      = npend_r[PEND_AW-1:0] + 1'b1;
    pw0_d      = acc[7:0];
    pw1_d      = acc[15:8];
    stream_clr = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_CHECK_INTERVAL: begin
          ci_nxt   = cfg_wdata;
          modp_nxt = 1'b1;
        end
        CFG_START_PERCENT: sp_nxt  = cfg_wdata[6:0];
        CFG_PERCENT_CAP:   cap_nxt = cfg_wdata[6:0];
        default: ;
      endcase
    end

    case (state_r)
      B_IDLE: begin
        if (modp_r) begin
          modp_nxt = 1'b0;
          mcnt_nxt = '0;
          macc_nxt = '0;
          msh_nxt  = cons_r;
        end else if (cmd_valid) begin
          cmd_nxt   = cmd;
          npend_nxt = '0;
          oidx_nxt  = '0;
          rej_nxt   = 1'b0;
          if (abort_r) begin
            if (cmd.last) stream_clr = 1'b1;
          end else if (cmd.first) begin
            rp_nxt = sp_r;
          end
        end
      end
      B_MOD: begin
        // one remainder bit per cycle
        macc_nxt = (mtry >= {1'b0, ci_r}) ? mtry - {1'b0, ci_r} : mtry;
        msh_nxt  = msh_r << 1;
        mcnt_nxt = mcnt_r + 1'b1;
        if (mcnt_r == CNT_IDX_W'(COUNT_BITS-1)) rem_nxt = macc_nxt[15:0];
      end
      B_MISS, B_CLR, B_FIN, B_END: begin
        pw0_en    = (nb != 2'd0);
        pw1_en    = (nb == 2'd2);
        npend_nxt = npend_r + (PEND_AW+1)'(nb);
        emit_nxt  = emit_r + COUNT_BITS'(nb);
        buf_nxt   = pk_buf;
        held_nxt  = nbits[2:0];
      end
      B_CNT: begin
        cons_nxt = cons_inc;
        rem_nxt  = rem_step;
      end
      B_PMUL: begin
        lt_nxt = {1'b0, cons_r} < saved;
        pa_nxt = times100(pdiff);
        pb_nxt = {{(PROD_W-7){1'b0}}, rp_r} * {7'b0, cons_r};
      end
      B_PCMP: begin
        if (pfail) begin
          rej_nxt   = 1'b1;
          npend_nxt = (PEND_AW+1)'(1);
        end else begin
          rp_nxt = (rp2 > {1'b0, cap_r}) ? cap_r : rp2[6:0];
        end
      end
      B_FLUSH: begin
        if (held_r != '0) begin
          pw0_en    = 1'b1;
          pw0_d     = buf_r;
          npend_nxt = npend_r + 1'b1;
          emit_nxt  = emit_r + 1'b1;
          buf_nxt   = '0;
          held_nxt  = '0;
        end
      end
      B_FMUL: begin
        neg_nxt  = fneg;
        zero_nxt = (cons_r == '0);
        pa_nxt   = times100(fdiff);
        pb_nxt   = fneg ? {7'b0, cons_r} : {{(PROD_W-7){1'b0}}, rp_r} * {7'b0, cons_r};
      end
      B_FCMP: begin
        if (ffail) begin
          rej_nxt   = 1'b1;
          npend_nxt = (PEND_AW+1)'(1);
        end
      end
      B_OUT: begin
        if (out_ch.valid && out_ch.ready) oidx_nxt = oidx_r + 1'b1;
        if (done_out) begin
          if (cmd_r.last) stream_clr = 1'b1;
          else if (rej_r) abort_nxt = 1'b1;
        end
      end
      default: ;
    endcase

    if (stream_clr) begin
      cons_nxt  = '0;
      emit_nxt  = '0;
      rem_nxt   = '0;
      buf_nxt   = '0;
      held_nxt  = '0;
      abort_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pw0_en) pend_r[pw0_a] <= pw0_d;
    if (pw1_en) pend_r[pw1_a] <= pw1_d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ci_r    <= 16'd200;
      sp_r    <= 7'd5;
      cap_r   <= 7'd10;
      rp_r    <= 7'd5;
      cons_r  <= '0;
      emit_r  <= '0;
      rem_r   <= '0;
      buf_r   <= '0;
      held_r  <= '0;
      abort_r <= 1'b0;
      npend_r <= '0;
      oidx_r  <= '0;
      rej_r   <= 1'b0;
      modp_r  <= 1'b0;
      mcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ci_r    <= ci_nxt;
      sp_r    <= sp_nxt;
      cap_r   <= cap_nxt;
      rp_r    <= rp_nxt;
      cons_r  <= cons_nxt;
      emit_r  <= emit_nxt;
      rem_r   <= rem_nxt;
      buf_r   <= buf_nxt;
      held_r  <= held_nxt;
      abort_r <= abort_nxt;
      npend_r <= npend_nxt;
      oidx_r  <= oidx_nxt;
      rej_r   <= rej_nxt;
      modp_r  <= modp_nxt;
      mcnt_r  <= mcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    macc_r <= macc_nxt;
    msh_r  <= msh_nxt;
    pa_r   <= pa_nxt;
    pb_r   <= pb_nxt;
    lt_r   <= lt_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
  end

endmodule

/* rtl/core/lzw_compressor_9_to_12_bit.sv */
// top level of the lzw compressor with 9 to 12 bit codes
// in_ch takes one raw byte per word, in_last marks the final byte of a block.
// out_ch gives the packed stream one byte per word, lsb first; run_last ends
// the words of one input byte, stream_end marks the final byte of the stream,
// rejected flags a failed ratio check (the stream is then dropped until in_last).
// the front end walks the trie one dictionary read per cycle, one read per entry
// visited, and writes a new entry in the states F_WR1 and F_WR2; the first byte
// of a stream needs no search.
// a four-entry command queue feeds the back end, which packs codes, counts
// bytes and runs the ratio checks, then sends 0 to 7 words.
// writing check_interval starts a remainder pass that holds the back end.
// reset is synchronous: the dictionary roots are emptied through valid bits,
// no clearing pass is needed; registers return to 200, 5 and 10.
// when out_ch stalls the back end waits while the front end keeps searching
// until the queue is full, then in_ch.ready drops.
`timescale 1ns / 1ps
module lzw_compressor_9_to_12_bit
  import lzw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  lzw_in_if.sink               in_ch,
  lzw_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata
);

  cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_ready;

  lzw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (f_cmd),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready)
  );

  lzw_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (f_cmd),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_data   (q_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  lzw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_cmd),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_ch    (out_ch)
  );

endmodule

/* rtl/core/lzw_chk.sv */
// port checker of the lzw compressor and its bind
`timescale 1ns / 1ps
module lzw_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       stream_end,
  input logic       rejected
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte))
    else $error("result byte changed while stalled");

  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && rejected |-> run_last && !stream_end && out_byte == 8'd0)
    else $error("bad reject word");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && stream_end |-> run_last)
    else $error("stream end not on last word of run");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind lzw_compressor_9_to_12_bit lzw_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .run_last   (out_ch.run_last),
  .stream_end (out_ch.stream_end),
  .rejected   (out_ch.rejected)
);

/* sim/testbench.sv */
// self-checking testbench of the lzw compressor with 9 to 12 bit codes
`timescale 1ns / 1ps
module testbench;
  import lzw_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;
    logic       rejected;
  } word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_wdata;

  lzw_in_if in_if ();
  lzw_out_if out_if ();

  lzw_compressor_9_to_12_bit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // compressor shadow state
  logic [11:0] trie_child[DICT_ENTRIES];
  logic [11:0] trie_sib[DICT_ENTRIES];
  logic [7:0]  trie_sym[DICT_ENTRIES];
  int unsigned cur_code;
  bit          cur_valid;
  int unsigned free_code;
  logic [7:0]  pack_buf;
  int unsigned pack_bits;
  logic [31:0] n_consumed;
  logic [31:0] n_emitted;
  int unsigned need_pct;
  bit          stream_dead;
  int unsigned reg_interval;
  int unsigned reg_start;
  int unsigned reg_cap;
  logic [7:0]  step_bytes[$];
  word_t       expected_words[$];

  int errors;
  bit calm;
  int quiet_cycles;

  function automatic void empty_roots();
    for (int i = 0; i <= CODE_EOS; i++) begin
      trie_child[i] = '0;
      trie_sib[i] = '0;
      trie_sym[i] = i[7:0];
    end
  endfunction

  function automatic void open_stream();
    empty_roots();
    cur_code = 0;
    cur_valid = 0;
    free_code = CODE_FIRST;
    pack_buf = '0;
    pack_bits = 0;
    n_consumed = '0;
    n_emitted = '0;
    need_pct = reg_start;
    stream_dead = 0;
  endfunction

  function automatic void pack_code(input int unsigned code);
    int unsigned w;
    int unsigned acc;
    int unsigned n;
    if (free_code > 2048) w = 12;
    else if (free_code > 1024) w = 11;
    else if (free_code > 512) w = 10;
    else w = 9;
    code = code & ((1 << w) - 1);
    acc = pack_buf | (code << pack_bits);
    n = pack_bits + w;
    while (n >= 8) begin
      step_bytes.push_back(acc[7:0]);
      n_emitted = n_emitted + 1;
      acc = acc >> 8;
      n = n - 8;
    end
    pack_buf = acc[7:0];
    pack_bits = n;
  endfunction

  function automatic bit ratio_low(input longint saved, input bit periodic);
    longint passed;
    longint q;
    passed = longint'(n_consumed);
    if (passed == 0) return 0;
    if (periodic && passed < saved) return 1;
    q = (passed - saved) * 100 / passed;
    return q < longint'(need_pct);
  endfunction

  function automatic void compress_byte(input logic [7:0] c, input logic last);
    bit reject;
    bit found;
    int unsigned s, sp, sn, nc, guard;
    longint saved;
    int unsigned p;
    word_t w;
    reject = 0;
    step_bytes.delete();
    if (stream_dead) begin
      if (last) open_stream();
      return;
    end
    if (!cur_valid) begin
      need_pct = reg_start;
      cur_code = c;
      cur_valid = 1;
    end else begin
      s = cur_code & (DICT_ENTRIES - 1);
      sp = s;
      sn = trie_child[s];
      guard = 0;
      found = 0;
      while (sn != 0 && guard < DICT_ENTRIES) begin
        if (trie_sym[sn] == c) begin
          found = 1;
          break;
        end
        sp = sn;
        sn = trie_sib[sn];
        guard++;
      end
      if (found) begin
        cur_code = sn;
      end else begin
        nc = free_code & (DICT_ENTRIES - 1);
        pack_code(s);
        if (sp == s) trie_child[s] = nc[11:0];
        else trie_sib[sp] = nc[11:0];
        trie_child[nc] = '0;
        trie_sib[nc] = '0;
        trie_sym[nc] = c;
        free_code++;
        if (free_code >= DICT_ENTRIES) begin
          pack_code(CODE_CLEAR);
          empty_roots();
          free_code = CODE_FIRST;
        end
        cur_code = c;
      end
    end
    n_consumed = n_consumed + 1;
    if (reg_interval != 0 && n_consumed != 0 && (n_consumed % reg_interval) == 0) begin
      saved = longint'(n_emitted);
      if (pack_bits > 0 || n_emitted == 0) saved++;
      if (ratio_low(saved, 1)) begin
        reject = 1;
      end else begin
        p = need_pct * 2;
        if (p > reg_cap) p = reg_cap;
        need_pct = p & 8'h7f;
      end
    end
    if (!reject && last) begin
      pack_code(cur_code);
      free_code++;
      pack_code(CODE_EOS);
      if (pack_bits > 0) begin
        step_bytes.push_back(pack_buf);
        n_emitted = n_emitted + 1;
        pack_buf = '0;
        pack_bits = 0;
      end
      if (ratio_low(longint'(n_emitted), 0)) reject = 1;
    end
    if (reject) begin
      w = '{out_byte: 8'h00, run_last: 1'b1, stream_end: 1'b0, rejected: 1'b1};
      expected_words.push_back(w);
      if (last) open_stream();
      else stream_dead = 1;
      return;
    end
    for (int k = 0; k < step_bytes.size(); k++) begin
      w.out_byte = step_bytes[k];
      w.run_last = (k == step_bytes.size() - 1);
      w.stream_end = last && (k == step_bytes.size() - 1);
      w.rejected = 1'b0;
      expected_words.push_back(w);
    end
    if (last) open_stream();
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result side stalls
  initial begin
    int stall;
    out_if.ready = 1'b1;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        out_if.ready <= (stall == 0);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 14);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word 0x%02h", out_if.out_byte);
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (out_if.out_byte !== want.out_byte) begin
          $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, out_if.out_byte);
          errors++;
        end
        if (out_if.run_last !== want.run_last) begin
          $error("run_last: expected %0d, got %0d", want.run_last, out_if.run_last);
          errors++;
        end
        if (out_if.stream_end !== want.stream_end) begin
          $error("stream_end: expected %0d, got %0d", want.stream_end, out_if.stream_end);
          errors++;
        end
        if (out_if.rejected !== want.rejected) begin
          $error("rejected: expected %0d, got %0d", want.rejected, out_if.rejected);
          errors++;
        end
      end
    end
  end

  // watchdog on handshake inactivity
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 20000) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic last);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_last <= last;
    do @(posedge clk); while (!in_if.ready);
    compress_byte(b, last);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CHECK_INTERVAL: reg_interval = val & 16'hffff;
      CFG_START_PERCENT:  reg_start = val & 8'h7f;
      CFG_PERCENT_CAP:    reg_cap = val & 8'h7f;
      default: ;
    endcase
    repeat (40) @(posedge clk);
  endtask

  // repetitive stream over a small alphabet, or noise when span is 256
  task automatic send_stream(input int len, input int span);
    logic [7:0] base;
    base = 8'($urandom_range(0, 255));
    for (int i = 0; i < len; i++)
      send_word(base + 8'($urandom_range(0, span - 1)), i == len - 1);
  endtask

  task automatic test_extremes();
    send_word(8'h00, 1'b1);
    send_word(8'hff, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'hff, 1'b1);
    for (int i = 0; i < 12; i++) send_word(8'h55 ^ {8{i[0]}}, i == 11);
    settle();
  endtask

  task automatic test_check_settings();
    write_reg(CFG_CHECK_INTERVAL, 1);
    write_reg(CFG_START_PERCENT, 0);
    write_reg(CFG_PERCENT_CAP, 0);
    send_stream(16, 2);
    settle();
    write_reg(CFG_CHECK_INTERVAL, 10);
    write_reg(CFG_START_PERCENT, 1);
    write_reg(CFG_PERCENT_CAP, 100);
    send_stream(12, 1);
    send_stream(12, 3);
    settle();
    write_reg(CFG_CHECK_INTERVAL, 65535);
    write_reg(CFG_START_PERCENT, 100);
    send_stream(16, 2);
    settle();
  endtask

  // early rejection, then ignored bytes until the block end
  task automatic test_abort();
    write_reg(CFG_CHECK_INTERVAL, 3);
    write_reg(CFG_START_PERCENT, 100);
    write_reg(CFG_PERCENT_CAP, 100);
    send_stream(12, 256);
    send_stream(5, 1);
    settle();
  endtask

  task automatic test_random();
    int sent;
    int span;
    int len;
    write_reg(CFG_CHECK_INTERVAL, $urandom_range(8, 40));
    write_reg(CFG_START_PERCENT, $urandom_range(0, 20));
    write_reg(CFG_PERCENT_CAP, $urandom_range(0, 60));
    sent = 0;
    while (sent < 55) begin
      if (sent >= 35) calm = 1;
      span = ($urandom_range(0, 4) == 0) ? 256 : $urandom_range(1, 4);
      len = $urandom_range(1, 15);
      send_stream(len, span);
      sent += len;
    end
    settle();
  endtask

  initial begin
    errors = 0;
    calm = 0;
    reg_interval = 200;
    reg_start = 5;
    reg_cap = 10;
    for (int i = 0; i < DICT_ENTRIES; i++) begin
      trie_child[i] = '0;
      trie_sib[i] = '0;
      trie_sym[i] = '0;
    end
    open_stream();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.in_byte = '0;
    in_if.in_last = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_check_settings();
    test_abort();
    test_random();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
